@@ design/angular_sector_visibility_filter_defines.svh @@
// assertion macros for the sector filter
`ifndef ANGULAR_SECTOR_VISIBILITY_FILTER_DEFINES_SVH
`define ANGULAR_SECTOR_VISIBILITY_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASVF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASVF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASVF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASVF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ design/asvf_pkg.sv @@
`default_nettype none
package asvf_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int DW = 33;
  localparam int CW = DW + CORDIC_STAGES + 3;
  localparam int SW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  localparam logic [31:0] ATAN_TABLE [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam logic [31:0] HALF_TURN        = 32'h8000_0000;
  localparam logic [31:0] ROUND_HALF       = 32'h0000_8000;
  localparam logic [15:0] HALF_WIDTH_RESET = 16'd4172;

  localparam logic KIND_SHIP    = 1'b0;
  localparam logic KIND_MISSILE = 1'b1;

  typedef enum logic [2:0] {
    REG_OBSERVER_X  = 3'd0,
    REG_OBSERVER_Y  = 3'd1,
    REG_RADAR_HEAD  = 3'd2,
    REG_HALF_WIDTH  = 3'd3,
    REG_SELF_INDEX  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic              kind;
    logic [3:0]        idx;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic [15:0]       heading;
    logic signed [7:0] speed;
    logic [3:0]        team;
    logic              last;
  } meta_t;

  typedef struct packed {
    logic                 zero;
    meta_t                meta;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
  } pipe_t;

endpackage
`default_nettype wire

@@ design/asvf_cordic_stage.sv @@
`default_nettype none
module asvf_cordic_stage (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic [asvf_pkg::SW-1:0] stage_idx,
  input  wire logic [31:0]             atan_step,
  input  wire logic                    in_valid,
  input  wire asvf_pkg::pipe_t         in_data,
  output logic                         out_valid_r,
  output asvf_pkg::pipe_t              out_data_r
);
  import asvf_pkg::*;

  pipe_t                data_nxt;
  logic signed [CW-1:0] x_sh;
  logic signed [CW-1:0] y_sh;

  always_comb begin
    x_sh     = $signed(in_data.x) >>> stage_idx;
    y_sh     = $signed(in_data.y) >>> stage_idx;
    data_nxt = in_data;
    if (!in_data.y[CW-1]) begin
      data_nxt.x = in_data.x + y_sh;
      data_nxt.y = in_data.y - x_sh;
      data_nxt.z = in_data.z + atan_step;
    end else begin
      data_nxt.x = in_data.x - y_sh;
      data_nxt.y = in_data.y + x_sh;
      data_nxt.z = in_data.z - atan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/angular_sector_visibility_filter.sv @@
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | object kind, index, position, attributes
// out     | output    | out_valid / out_ready | visible flag and copied attributes
// cfg     | input     | cfg_valid / cfg_ready | register index, write data
//
// one item per cycle unless the output stalls; the pipeline holds an unrolled vectoring
// cordic, one iteration per register stage
// synchronous active-low reset clears the valid bits and loads register defaults
// a stalled output freezes the whole pipeline; in_ready follows the output register
// cfg_ready is always high
`default_nettype none
`include "angular_sector_visibility_filter_defines.svh"
module angular_sector_visibility_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_object_kind,
  input  wire logic [3:0]  in_object_index,
  input  wire logic signed [31:0] in_target_x,
  input  wire logic signed [31:0] in_target_y,
  input  wire logic [15:0] in_heading,
  input  wire logic signed [7:0] in_speed,
  input  wire logic [3:0]  in_team,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_visible,
  output logic             out_kind,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [15:0]      out_heading,
  output logic signed [7:0] out_speed,
  output logic [3:0]       out_team,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import asvf_pkg::*;

  logic signed [31:0] observer_x_r;
  logic signed [31:0] observer_y_r;
  logic [15:0]        radar_heading_r;
  logic [15:0]        half_width_r;
  logic [3:0]         self_index_r;

  logic adv;

  // stage 0: differences
  logic                  v0_r;
  meta_t                 meta0_r;
  logic signed [DW-1:0]  dx_r;
  logic signed [DW-1:0]  dy_r;

  // stage 1: half-turn patch and scaling
  logic signed [DW-1:0]  xn;
  logic signed [DW-1:0]  yn;
  pipe_t                 pre_nxt;

  pipe_t                 stg_data_r [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] stg_valid_r;

  // output stage
  pipe_t                 fin;
  logic                  fin_take;
  logic [31:0]           rnd;
  logic [15:0]           bearing;
  logic [15:0]           diff;
  logic signed [17:0]    sd;
  logic signed [17:0]    hw;
  logic                  in_sector;
  logic                  self_hit;
  logic                  out_valid_r;
  logic                  visible_r;
  meta_t                 out_meta_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      observer_x_r    <= '0;
      observer_y_r    <= '0;
      radar_heading_r <= '0;
      half_width_r    <= HALF_WIDTH_RESET;
      self_index_r    <= '0;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_OBSERVER_X: observer_x_r    <= cfg_data;
        REG_OBSERVER_Y: observer_y_r    <= cfg_data;
        REG_RADAR_HEAD: radar_heading_r <= cfg_data[15:0];
        REG_HALF_WIDTH: half_width_r    <= cfg_data[15:0];
        REG_SELF_INDEX: self_index_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta0_r.kind    <= in_object_kind;
      meta0_r.idx     <= in_object_index;
      meta0_r.tx      <= in_target_x;
      meta0_r.ty      <= in_target_y;
      meta0_r.heading <= in_heading;
      meta0_r.speed   <= in_speed;
      meta0_r.team    <= in_team;
      meta0_r.last    <= in_is_last;
      dx_r <= DW'(in_target_x) - DW'(observer_x_r);
      dy_r <= DW'(in_target_y) - DW'(observer_y_r);
    end
  end

  always_comb begin
    pre_nxt.zero = (dx_r == '0) && (dy_r == '0);
    pre_nxt.meta = meta0_r;
    if (dx_r[DW-1]) begin
      xn = -dx_r;
      yn = -dy_r;
      pre_nxt.z = HALF_TURN;
    end else begin
      xn = dx_r;
      yn = dy_r;
      pre_nxt.z = '0;
    end
    pre_nxt.x = CW'(xn) <<< CORDIC_STAGES;
    pre_nxt.y = CW'(yn) <<< CORDIC_STAGES;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r[0] <= 1'b0;
    end else if (adv) begin
      stg_valid_r[0] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_data_r[0] <= pre_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    asvf_cordic_stage u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (adv),
      .stage_idx   (SW'(i)),
      .atan_step   (ATAN_TABLE[i]),
      .in_valid    (stg_valid_r[i]),
      .in_data     (stg_data_r[i]),
      .out_valid_r (stg_valid_r[i+1]),
      .out_data_r  (stg_data_r[i+1])
    );
  end

  assign fin_take = stg_valid_r[CORDIC_STAGES] && adv;

  always_comb begin
    fin       = stg_data_r[CORDIC_STAGES];
    rnd       = fin.z + ROUND_HALF;
    bearing   = fin.zero ? 16'd0 : rnd[31:16];
    diff      = bearing - radar_heading_r;
    sd        = 18'($signed(diff));
    hw        = $signed({2'b00, half_width_r});
    in_sector = (sd < hw) && (sd > -hw);
    self_hit  = (fin.meta.kind == KIND_SHIP) && (fin.meta.idx == self_index_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= stg_valid_r[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      visible_r  <= in_sector && !self_hit;
      out_meta_r <= fin.meta;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = visible_r;
  assign out_kind    = out_meta_r.kind;
  assign out_x       = out_meta_r.tx;
  assign out_y       = out_meta_r.ty;
  assign out_heading = out_meta_r.heading;
  assign out_speed   = out_meta_r.speed;
  assign out_team    = out_meta_r.team;
  assign out_last    = out_meta_r.last;

  `ASVF_ASSERT_NXT(a_stall_freezes, clk, rst_n, !adv, $stable(stg_valid_r) && $stable(v0_r))
  `ASVF_ASSERT_NXT(a_self_hidden, clk, rst_n, fin_take && self_hit, !out_visible)
  `ASVF_ASSERT_NXT(a_zero_width, clk, rst_n, fin_take && (half_width_r == '0), !out_visible)

endmodule
`default_nettype wire
